FILE: sv/rdpd_pkg.sv
package rdpd_pkg;

  localparam int MAX_PAYLOAD_DEF = 2048;

  localparam int LEN_W  = 12;
  localparam int DATA_W = 7;
  localparam int KIND_W = 2;

  localparam logic [6:0] CH_START = 7'h24;
  localparam logic [6:0] CH_END   = 7'h23;
  localparam logic [6:0] CH_ACK   = 7'h2B;
  localparam logic [6:0] CH_NAK   = 7'h2D;

  typedef enum logic [KIND_W-1:0] {
    KIND_CHAR   = 2'd0,
    KIND_ACCEPT = 2'd1,
    KIND_REJECT = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [DATA_W-1:0]  data;
    logic [LEN_W-1:0]   length;
    logic               overflow;
  } result_t;

endpackage

FILE: sv/rdpd_core.sv
module rdpd_core #(
  parameter int MAX_PAYLOAD = rdpd_pkg::MAX_PAYLOAD_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_accept,
  input  logic [7:0]        in_byte,
  output logic              res_valid,
  output rdpd_pkg::result_t res
);
  import rdpd_pkg::*;

  localparam int CW = $clog2(MAX_PAYLOAD + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_PAYLOAD);

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_BODY = 2'd1,
    PH_DIG1 = 2'd2,
    PH_DIG2 = 2'd3
  } phase_t;

  phase_t        phase, phase_next;
  logic [7:0]    running_sum, running_sum_next;
  logic [3:0]    high_digit, high_digit_next;
  logic [CW-1:0] char_count, char_count_next;
  logic          overflowed, overflowed_next;

  logic [6:0] c;
  logic [3:0] hex;
  logic       ok;

  assign c = in_byte[6:0];

  always_comb begin
    if (c >= 7'h30 && c <= 7'h39) begin
      hex = 4'(c - 7'h30);
    end else if (c >= 7'h61 && c <= 7'h66) begin
      hex = 4'(c - 7'h57);
    end else begin
      hex = 4'd0;
    end
  end

  assign ok = ({high_digit, hex} == running_sum);

  always_comb begin
    phase_next       = phase;
    running_sum_next = running_sum;
    high_digit_next  = high_digit;
    char_count_next  = char_count;
    overflowed_next  = overflowed;
    res_valid        = 1'b0;
    res.kind         = KIND_CHAR;
    res.data         = c;
    res.length       = LEN_W'(char_count);
    res.overflow     = 1'b0;
    unique case (phase)
      PH_HUNT: begin
        if (c == CH_START) begin
          running_sum_next = 8'd0;
          char_count_next  = '0;
          overflowed_next  = 1'b0;
          phase_next       = PH_BODY;
        end
      end
      PH_BODY: begin
        if (c == CH_END) begin
          phase_next = PH_DIG1;
        end else begin
          running_sum_next = running_sum + {1'b0, c};
          if (char_count >= MAX_CNT) begin
            char_count_next = MAX_CNT;
            overflowed_next = 1'b1;
          end else begin
            char_count_next = char_count + 1'b1;
            res_valid       = 1'b1;
            res.length      = LEN_W'(char_count_next);
          end
        end
      end
      PH_DIG1: begin
        high_digit_next = hex;
        phase_next      = PH_DIG2;
      end
      PH_DIG2: begin
        res_valid    = 1'b1;
        res.kind     = ok ? KIND_ACCEPT : KIND_REJECT;
        res.data     = ok ? CH_ACK : CH_NAK;
        res.overflow = overflowed;
        phase_next   = PH_HUNT;
      end
      default: begin
        phase_next = PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HUNT;
      running_sum <= 8'd0;
      high_digit  <= 4'd0;
      char_count  <= '0;
      overflowed  <= 1'b0;
    end else if (in_accept) begin
      phase       <= phase_next;
      running_sum <= running_sum_next;
      high_digit  <= high_digit_next;
      char_count  <= char_count_next;
      overflowed  <= overflowed_next;
    end
  end

endmodule

FILE: sv/rdpd_obuf.sv
module rdpd_obuf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  rdpd_pkg::result_t push_res,
  output logic              ready,
  output logic              out_valid,
  input  logic              out_ready,
  output rdpd_pkg::result_t out_res
);
  import rdpd_pkg::*;

  logic    main_valid, skid_valid;
  result_t main_res, skid_res;
  logic    pop;

  assign pop       = main_valid && out_ready;
  assign ready     = !skid_valid;
  assign out_valid = main_valid;
  assign out_res   = main_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (push) begin
      if (!main_valid || pop) begin
        main_valid <= 1'b1;
        main_res   <= push_res;
      end else begin
        skid_valid <= 1'b1;
        skid_res   <= push_res;
      end
    end else if (pop) begin
      if (skid_valid) begin
        main_res   <= skid_res;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: sv/remote_debug_packet_deframer.sv
// channel  dir  tdata                                      tuser
// s_axis   in   [7:0] rx_byte                              -
// m_axis   out  [6:0] data [18:7] length [19] overflow     [1:0] kind
//
// One word per cycle while s_axis_tready is high, set by the single phase state update per received byte.
// Reset is synchronous; it returns the deframer to hunting and empties the
// two-entry output buffer. s_axis_tready drops only while both output entries
// are held by a stalled m_axis.
module remote_debug_packet_deframer #(
  parameter int MAX_PAYLOAD = rdpd_pkg::MAX_PAYLOAD_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // data, length, overflow, zero fill
  output logic [1:0]  m_axis_tuser    // kind
);
  import rdpd_pkg::*;

  logic    accept;
  logic    res_valid;
  result_t res, out_res;

  assign accept = s_axis_tvalid && s_axis_tready;

  rdpd_core #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .in_accept(accept),
    .in_byte  (s_axis_tdata),
    .res_valid(res_valid),
    .res      (res)
  );

  rdpd_obuf u_obuf (
    .clk      (clk),
    .rst      (rst),
    .push     (accept && res_valid),
    .push_res (res),
    .ready    (s_axis_tready),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_res  (out_res)
  );

  assign m_axis_tdata = {4'd0, out_res.overflow, out_res.length, out_res.data};
  assign m_axis_tuser = out_res.kind;

endmodule
